// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the flow vector block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define HFVA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset
`define HFVA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hfva_pkg.sv =====
// Shared types, constants and the arctangent table of the flow vector block.
// Depends on nothing; used by every module of the block.
package hfva_pkg;

    localparam int MAX_TRACKS  = 4096;
    localparam int ANGLE_BITS  = 16;
    localparam int CNT_W       = $clog2(MAX_TRACKS + 1);
    localparam int ITER_W      = $clog2(ANGLE_BITS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CORDIC_X0   = 79594;
    localparam int MAG_GAIN    = 39797;

    typedef enum logic [2:0] {
        REG_ETA_MIN      = 3'd0,
        REG_ETA_MAX      = 3'd1,
        REG_PT_MIN       = 3'd2,
        REG_PT_MAX       = 3'd3,
        REG_HARMONIC     = 3'd4,
        REG_PT_WEIGHTING = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_MAP,
        ST_PROD,
        ST_ACC,
        ST_VINIT,
        ST_VEC,
        ST_MAG,
        ST_MAG_SUM,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic        [15:0] track_phi;
        logic signed [15:0] track_eta;
        logic        [19:0] track_pt;
        logic        [15:0] track_weight;
        logic               has_track;
        logic               last_in_event;
    } t_track;

    typedef struct packed {
        logic signed [15:0] sum_angle;
        logic        [47:0] sum_magnitude;
        logic        [47:0] weight_total;
    } t_result;

    typedef struct packed {
        logic signed [15:0] eta_min;
        logic signed [15:0] eta_max;
        logic        [19:0] pt_min;
        logic        [19:0] pt_max;
        logic        [4:0]  harmonic;
        logic               pt_weighting;
    } t_cfg;

    // One request handed from the front to the back
    typedef struct packed {
        logic [15:0] angle;
        logic [19:0] pt;
        logic [15:0] weight;
        logic        keep;
        logic        last;
    } t_job;

    // atan(2^-i) on a 32-bit turn scale
    function automatic logic [31:0] atan_of(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/hfva_front.sv =====
// Front end: accepts tracks, applies the windows and track limit, forms the angle.
// Depends on hfva_pkg; feeds hfva_queue.
module hfva_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hfva_pkg::t_cfg    i_cfg,
    input  logic              i_push,
    input  hfva_pkg::t_track  i_track,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_q_push,
    output hfva_pkg::t_job    o_job
);

    logic [hfva_pkg::CNT_W-1:0] r_count;
    logic [hfva_pkg::CNT_W-1:0] n_count;
    logic                       accept;
    logic                       room;
    logic                       in_window;
    logic                       keep;
    logic [20:0]                prod;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign room   = r_count < hfva_pkg::CNT_W'(hfva_pkg::MAX_TRACKS);

    // Classify the track against the inclusive windows
    assign in_window = (i_track.track_eta >= i_cfg.eta_min) &&
                       (i_track.track_eta <= i_cfg.eta_max) &&
                       (i_track.track_pt >= i_cfg.pt_min) &&
                       (i_track.track_pt <= i_cfg.pt_max);
    assign keep = i_track.has_track && room && in_window;

    // Harmonic times azimuth, modulo a full turn
    assign prod = i_track.track_phi * i_cfg.harmonic;

    assign o_q_push     = accept && (keep || i_track.last_in_event);
    assign o_job.angle  = prod[15:0];
    assign o_job.pt     = i_track.track_pt;
    assign o_job.weight = i_track.track_weight;
    assign o_job.keep   = keep;
    assign o_job.last   = i_track.last_in_event;

    // Count tracks of the event, drop the count at its end
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_track.last_in_event) begin
                n_count = '0;
            end else if (i_track.has_track && room) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== src/hfva_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on hfva_pkg.
module hfva_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hfva_pkg::t_job  i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output hfva_pkg::t_job  o_data
);

    hfva_pkg::t_job                r_mem [hfva_pkg::QUEUE_DEPTH];
    logic [hfva_pkg::QUEUE_AW-1:0] r_wr;
    logic [hfva_pkg::QUEUE_AW-1:0] r_rd;
    logic [hfva_pkg::QUEUE_AW:0]   r_fill;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = r_fill == (hfva_pkg::QUEUE_AW+1)'(hfva_pkg::QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== src/hfva_back.sv =====
// Back end: sine-cosine CORDIC, accumulation, vectoring CORDIC and result register.
// Depends on hfva_pkg; drains hfva_queue.
module hfva_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pt_weighting,
    input  logic              i_q_empty,
    input  hfva_pkg::t_job    i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output hfva_pkg::t_result o_result
);

    localparam logic [hfva_pkg::ITER_W-1:0] LAST_ITER = hfva_pkg::ITER_W'(hfva_pkg::ANGLE_BITS - 1);

    hfva_pkg::t_back_state r_state;
    hfva_pkg::t_back_state n_state;

    hfva_pkg::t_job                r_job;
    logic [hfva_pkg::ITER_W-1:0]   r_iter;
    logic signed [19:0]            r_x;
    logic signed [19:0]            r_y;
    logic signed [32:0]            r_z;
    logic signed [15:0]            r_c;
    logic signed [15:0]            r_s;
    logic signed [36:0]            r_re_term;
    logic signed [36:0]            r_im_term;
    logic [35:0]                   r_w_term;
    logic signed [47:0]            r_re_sum;
    logic signed [47:0]            r_im_sum;
    logic [47:0]                   r_w_sum;
    logic signed [50:0]            r_vx;
    logic signed [50:0]            r_vy;
    logic [31:0]                   r_vz;
    logic                          r_zero;
    logic [49:0]                   r_p_hi;
    logic [32:0]                   r_p_lo;
    logic [15:0]                   r_angle;
    logic [47:0]                   r_mag;
    logic                          r_res_valid;
    hfva_pkg::t_result             r_res;

    logic                          slot_free;
    logic                          last_iter;
    logic [31:0]                   atan_now;
    logic signed [15:0]            qx;
    logic signed [15:0]            qy;
    logic [19:0]                   scale;
    logic signed [48:0]            re_add;
    logic signed [48:0]            im_add;
    logic [48:0]                   w_add;
    logic [49:0]                   ux;
    logic [50:0]                   m_sum;
    logic [31:0]                   vz_round;

    // Round a CORDIC output to Q1.15 and clamp
    function automatic logic signed [15:0] to_q15(input logic signed [19:0] v);
        logic signed [20:0] t;
        t = ($signed({v[19], v}) + 21'sd2) >>> 2;
        if (t > 21'sd32767) begin
            return 16'sd32767;
        end else if (t < -21'sd32767) begin
            return -16'sd32767;
        end
        return t[15:0];
    endfunction

    // Saturate a 49-bit signed sum to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47]) begin
            return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return v[47:0];
    endfunction

    assign slot_free = !r_res_valid || i_pop;
    assign last_iter = r_iter == LAST_ITER;
    assign atan_now  = hfva_pkg::atan_of(5'(r_iter));
    assign qx        = to_q15(r_x);
    assign qy        = to_q15(r_y);
    assign scale     = i_pt_weighting ? r_job.pt : 20'd256;
    assign re_add    = $signed({r_re_sum[47], r_re_sum}) + 49'(r_re_term);
    assign im_add    = $signed({r_im_sum[47], r_im_sum}) + 49'(r_im_term);
    assign w_add     = {1'b0, r_w_sum} + {13'd0, r_w_term};
    assign ux        = r_vx[50] ? 50'd0 : r_vx[49:0];
    assign m_sum     = {1'b0, r_p_hi} + {35'd0, r_p_lo[31:16]};
    assign vz_round  = r_vz + 32'h0000_8000;

    assign o_empty  = !r_res_valid;
    assign o_result = r_res;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hfva_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_data.keep ? hfva_pkg::ST_ROT : hfva_pkg::ST_VINIT;
                end
            end
            hfva_pkg::ST_ROT: begin
                if (last_iter) begin
                    n_state = hfva_pkg::ST_MAP;
                end
            end
            hfva_pkg::ST_MAP:   n_state = hfva_pkg::ST_PROD;
            hfva_pkg::ST_PROD:  n_state = hfva_pkg::ST_ACC;
            hfva_pkg::ST_ACC: begin
                n_state = r_job.last ? hfva_pkg::ST_VINIT : hfva_pkg::ST_IDLE;
            end
            hfva_pkg::ST_VINIT: n_state = hfva_pkg::ST_VEC;
            hfva_pkg::ST_VEC: begin
                if (last_iter) begin
                    n_state = hfva_pkg::ST_MAG;
                end
            end
            hfva_pkg::ST_MAG:     n_state = hfva_pkg::ST_MAG_SUM;
            hfva_pkg::ST_MAG_SUM: n_state = hfva_pkg::ST_EMIT;
            hfva_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_state = hfva_pkg::ST_IDLE;
                end
            end
            default: n_state = hfva_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_q_pop = 1'b0;
        case (r_state)
            hfva_pkg::ST_IDLE: o_q_pop = !i_q_empty;
            default:           o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfva_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: CORDIC iterations, products and magnitude scaling
    always_ff @(posedge i_clk) begin
        case (r_state)
            hfva_pkg::ST_IDLE: begin
                r_job  <= i_q_data;
                r_iter <= '0;
                r_x    <= 20'(hfva_pkg::CORDIC_X0);
                r_y    <= '0;
                r_z    <= $signed({3'd0, i_q_data.angle[13:0], 16'd0});
            end
            hfva_pkg::ST_ROT: begin
                r_iter <= r_iter + 1'b1;
                if (!r_z[32]) begin
                    r_x <= r_x - (r_y >>> r_iter);
                    r_y <= r_y + (r_x >>> r_iter);
                    r_z <= r_z - $signed({1'b0, atan_now});
                end else begin
                    r_x <= r_x + (r_y >>> r_iter);
                    r_y <= r_y - (r_x >>> r_iter);
                    r_z <= r_z + $signed({1'b0, atan_now});
                end
            end
            hfva_pkg::ST_MAP: begin
                case (r_job.angle[15:14])
                    2'd0:    begin r_c <= qx;  r_s <= qy;  end
                    2'd1:    begin r_c <= -qy; r_s <= qx;  end
                    2'd2:    begin r_c <= -qx; r_s <= -qy; end
                    default: begin r_c <= qy;  r_s <= -qx; end
                endcase
            end
            hfva_pkg::ST_PROD: begin
                r_re_term <= r_c * $signed({1'b0, scale});
                r_im_term <= r_s * $signed({1'b0, scale});
                r_w_term  <= i_pt_weighting ? 36'(r_job.pt * r_job.weight)
                                            : {12'd0, r_job.weight, 8'd0};
            end
            hfva_pkg::ST_VINIT: begin
                r_iter <= '0;
                r_zero <= (r_re_sum == '0) && (r_im_sum == '0);
                if (r_re_sum[47]) begin
                    r_vx <= -51'(r_re_sum);
                    r_vy <= -51'(r_im_sum);
                    r_vz <= 32'h8000_0000;
                end else begin
                    r_vx <= 51'(r_re_sum);
                    r_vy <= 51'(r_im_sum);
                    r_vz <= '0;
                end
            end
            hfva_pkg::ST_VEC: begin
                r_iter <= r_iter + 1'b1;
                if (r_vy[50]) begin
                    r_vx <= r_vx - (r_vy >>> r_iter);
                    r_vy <= r_vy + (r_vx >>> r_iter);
                    r_vz <= r_vz - atan_now;
                end else begin
                    r_vx <= r_vx + (r_vy >>> r_iter);
                    r_vy <= r_vy - (r_vx >>> r_iter);
                    r_vz <= r_vz + atan_now;
                end
            end
            hfva_pkg::ST_MAG: begin
                r_p_hi  <= 50'(ux[49:16] * 16'(hfva_pkg::MAG_GAIN));
                r_p_lo  <= 33'(ux[15:0] * 16'(hfva_pkg::MAG_GAIN)) + 33'd32768;
                r_angle <= vz_round[31:16];
            end
            hfva_pkg::ST_MAG_SUM: begin
                if (r_zero) begin
                    r_mag   <= '0;
                    r_angle <= '0;
                end else if (m_sum[50:48] != 3'd0) begin
                    r_mag <= {48{1'b1}};
                end else begin
                    r_mag <= m_sum[47:0];
                end
            end
            default: begin
                r_iter <= r_iter;
            end
        endcase
    end

    // Accumulate sums; clear them when the event result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re_sum <= '0;
            r_im_sum <= '0;
            r_w_sum  <= '0;
        end else if (r_state == hfva_pkg::ST_ACC) begin
            r_re_sum <= sat48(re_add);
            r_im_sum <= sat48(im_add);
            r_w_sum  <= w_add[48] ? {48{1'b1}} : w_add[47:0];
        end else if (r_state == hfva_pkg::ST_EMIT && slot_free) begin
            r_re_sum <= '0;
            r_im_sum <= '0;
            r_w_sum  <= '0;
        end
    end

    // Hold the result until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (r_state == hfva_pkg::ST_EMIT && slot_free) begin
            r_res_valid <= 1'b1;
        end else if (i_pop) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hfva_pkg::ST_EMIT && slot_free) begin
            r_res.sum_angle     <= r_angle;
            r_res.sum_magnitude <= r_mag;
            r_res.weight_total  <= r_w_sum;
        end
    end

endmodule

// ===== src/harmonic_flow_vector_accumulator.sv =====
// Top level of the harmonic flow vector accumulator: register port and wiring.
// Depends on hfva_pkg, hfva_front, hfva_queue and hfva_back.
//
// Tracks enter through push/full and are classified at once; kept tracks and
// event ends wait in a four-entry request queue. The back end works on one
// request at a time: a kept track takes 16 sine-cosine CORDIC iterations,
// quadrant mapping, product and accumulate, and an event end adds 16
// vectoring iterations, magnitude scaling and result load. Tracks outside the
// windows cost nothing at the back. The shared CORDIC iteration loop sets the
// rate. Results are popped from a one-entry register, and sums clear as the
// result is loaded.
module harmonic_flow_vector_accumulator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  hfva_pkg::t_track  i_track,
    output logic              empty,
    input  logic              pop,
    output hfva_pkg::t_result o_result
);

    hfva_pkg::t_cfg r_cfg;
    hfva_pkg::t_cfg n_cfg;
    hfva_pkg::t_job front_job;
    hfva_pkg::t_job q_job;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register write
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (hfva_pkg::t_reg_idx'(paddr[4:2]))
                hfva_pkg::REG_ETA_MIN:      n_cfg.eta_min      = pwdata[15:0];
                hfva_pkg::REG_ETA_MAX:      n_cfg.eta_max      = pwdata[15:0];
                hfva_pkg::REG_PT_MIN:       n_cfg.pt_min       = pwdata[19:0];
                hfva_pkg::REG_PT_MAX:       n_cfg.pt_max       = pwdata[19:0];
                hfva_pkg::REG_HARMONIC:     n_cfg.harmonic     = pwdata[4:0];
                hfva_pkg::REG_PT_WEIGHTING: n_cfg.pt_weighting = pwdata[0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eta_min      <= 16'sh8000;
            r_cfg.eta_max      <= 16'sh7FFF;
            r_cfg.pt_min       <= '0;
            r_cfg.pt_max       <= 20'hFFFFF;
            r_cfg.harmonic     <= 5'd2;
            r_cfg.pt_weighting <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Register read
    always_comb begin
        case (hfva_pkg::t_reg_idx'(paddr[4:2]))
            hfva_pkg::REG_ETA_MIN:      prdata = {16'd0, r_cfg.eta_min};
            hfva_pkg::REG_ETA_MAX:      prdata = {16'd0, r_cfg.eta_max};
            hfva_pkg::REG_PT_MIN:       prdata = {12'd0, r_cfg.pt_min};
            hfva_pkg::REG_PT_MAX:       prdata = {12'd0, r_cfg.pt_max};
            hfva_pkg::REG_HARMONIC:     prdata = {27'd0, r_cfg.harmonic};
            hfva_pkg::REG_PT_WEIGHTING: prdata = {31'd0, r_cfg.pt_weighting};
            default:                    prdata = '0;
        endcase
    end

    hfva_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_track  (i_track),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_job    (front_job)
    );

    hfva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    hfva_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pt_weighting (r_cfg.pt_weighting),
        .i_q_empty      (q_empty),
        .i_q_data       (q_job),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result       (o_result)
    );

endmodule

// ===== src/hfva_checker.sv =====
// Port-level checks of the flow vector block, bound to the top level.
// Depends on hfva_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hfva_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              pready,
    input logic              empty,
    input logic              pop,
    input hfva_pkg::t_result o_result
);

    `HFVA_ASSERT(a_res_holds, i_clk, i_rst_n, !empty && !pop |=> $stable(o_result), "result changed while waiting")
    `HFVA_ASSERT(a_res_stays, i_clk, i_rst_n, !empty && !pop |=> !empty, "result dropped without pop")
    `HFVA_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty, "result waiting after reset")
    `HFVA_ASSERT_ALWAYS(a_ready, i_clk, pready, "register port not ready")

endmodule

bind harmonic_flow_vector_accumulator hfva_checker u_hfva_checker (.*);
